FILE: rtl/bhkvt_pkg.sv
// Package for the bucketed hash key-value table: sizes, request and result types,
// status and operation codes, memory control struct and sequencer states.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bhkvt_pkg;

  // Table geometry. Both counts are powers of two, so the bucket is the low key bits
  // and a slot index is the bucket followed by the way.
  localparam int NUM_BUCKETS = 1024;
  localparam int WAYS        = 4;
  localparam int SLOT_COUNT  = NUM_BUCKETS * WAYS;
  localparam int BUCKET_W    = $clog2(NUM_BUCKETS);
  localparam int WAY_W       = $clog2(WAYS);
  localparam int SLOT_W      = $clog2(SLOT_COUNT);

  // Field widths of the request and result.
  localparam int OP_W       = 2;
  localparam int KEY_W      = 64;
  localparam int VAL_W      = 64;
  localparam int STATUS_W   = 2;
  localparam int SLOT_OUT_W = 12;

  // Reserved key codes.
  localparam logic [KEY_W-1:0] KEY_EMPTY   = '0;
  localparam logic [KEY_W-1:0] KEY_DELETED = '1;

  // Operation codes; the unused code behaves as a lookup.
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
  localparam logic [OP_W-1:0] OP_UPDATE = 2'd1;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

  // Status codes.
  localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_INVALID   = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]  operation;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0]   status;
    logic [VAL_W-1:0]      value_res;
    logic [SLOT_OUT_W-1:0] slot;
  } rsp_t;

  // Control from the sequencer to the key and value memories.
  typedef struct packed {
    logic              key_we;
    logic              val_we;
    logic [SLOT_W-1:0] wr_addr;
    logic [SLOT_W-1:0] rd_addr;
  } mem_ctl_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

FILE: rtl/bucketed_hash_key_value_table.sv
// Top level of the bucketed hash key-value table: key memory, value memory and
// sequencer. Depends on bhkvt_pkg, bhkvt_ram and bhkvt_seq.
//
//   channel   ports                          handshake
//   request   start, busy, request (req_t)   taken when start is high and busy is low
//   result    done, result (rsp_t)           one cycle per request, marked by done
//
// After reset the key memory is swept to empty, one slot per cycle; busy stays
// high meanwhile. A request with a bad key answers on the next cycle. Otherwise
// the bucket's ways are compared one per cycle through the key memory read port,
// up to WAYS of them per request.
// A new request may be taken in the cycle the result is shown; the receiver
// cannot hold a result off.
`timescale 1ns / 1ps
`default_nettype none

module bucketed_hash_key_value_table (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire bhkvt_pkg::req_t  request,
  output logic                  busy,
  output logic                  done,
  output bhkvt_pkg::rsp_t       result
);

  bhkvt_pkg::mem_ctl_t            mem_ctl;
  logic [bhkvt_pkg::KEY_W-1:0]    key_wdata;
  logic [bhkvt_pkg::KEY_W-1:0]    key_rdata;
  logic [bhkvt_pkg::VAL_W-1:0]    val_rdata;
  logic [bhkvt_pkg::KEY_W-1:0]    seq_key;
  logic [bhkvt_pkg::VAL_W-1:0]    u_seq_value_w;
  logic [bhkvt_pkg::VAL_W-1:0]    held_value;

  // Sequencer with the way compare unit.
  bhkvt_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .request   (request),
    .busy      (busy),
    .done      (done),
    .result    (result),
    .mem_ctl   (mem_ctl),
    .key_wdata (key_wdata),
    .key_rdata (key_rdata),
    .val_rdata (val_rdata)
  );

  assign seq_key = key_wdata;

  // Key memory, one slot per entry.
  bhkvt_ram #(
    .WIDTH (bhkvt_pkg::KEY_W),
    .DEPTH (bhkvt_pkg::SLOT_COUNT)
  ) u_key_ram (
    .clk   (clk),
    .we    (mem_ctl.key_we),
    .waddr (mem_ctl.wr_addr),
    .wdata (seq_key),
    .raddr (mem_ctl.rd_addr),
    .rdata (key_rdata)
  );

  // Value memory, written on an update, together with the key when a new slot is filled.
  bhkvt_ram #(
    .WIDTH (bhkvt_pkg::VAL_W),
    .DEPTH (bhkvt_pkg::SLOT_COUNT)
  ) u_val_ram (
    .clk   (clk),
    .we    (mem_ctl.val_we),
    .waddr (mem_ctl.wr_addr),
    .wdata (u_seq_value_w),
    .raddr (mem_ctl.rd_addr),
    .rdata (val_rdata)
  );

  // The word to store is the one carried by the request being served.
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      held_value <= request.value;
    end
  end

  assign u_seq_value_w = held_value;

endmodule

`default_nettype wire

FILE: rtl/bhkvt_ram.sv
// Generic simple dual-port RAM: one write port and one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module bhkvt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: rtl/bhkvt_seq.sv
// Sequencer and shared way compare unit of the bucketed hash key-value table.
// Depends on bhkvt_pkg; drives the key and value memories built in the top level.
`timescale 1ns / 1ps
`default_nettype none

module bhkvt_seq (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire bhkvt_pkg::req_t           request,
  output logic                           busy,
  output logic                           done,
  output bhkvt_pkg::rsp_t                result,
  output bhkvt_pkg::mem_ctl_t            mem_ctl,
  output logic [bhkvt_pkg::KEY_W-1:0]    key_wdata,
  input  wire logic [bhkvt_pkg::KEY_W-1:0] key_rdata,
  input  wire logic [bhkvt_pkg::VAL_W-1:0] val_rdata
);

  bhkvt_pkg::state_t                   state, state_next;
  logic [bhkvt_pkg::SLOT_W-1:0]        clr_addr, clr_addr_next;
  logic [bhkvt_pkg::OP_W-1:0]          op, op_next;
  logic [bhkvt_pkg::KEY_W-1:0]         key, key_next;
  logic [bhkvt_pkg::VAL_W-1:0]         value, value_next;
  logic [bhkvt_pkg::WAY_W-1:0]         way, way_next;
  logic                                free_vld, free_vld_next;
  logic [bhkvt_pkg::WAY_W-1:0]         free_way, free_way_next;
  bhkvt_pkg::rsp_t                     rsp, rsp_next;

  logic                                accept;
  logic                                key_bad;
  logic [bhkvt_pkg::BUCKET_W-1:0]      bucket;
  logic [bhkvt_pkg::BUCKET_W-1:0]      req_bucket;
  logic [bhkvt_pkg::SLOT_W-1:0]        cur_addr;
  logic                                slot_empty;
  logic                                slot_del;
  logic                                slot_hit;
  logic                                last_way;
  logic                                free_here;
  logic [bhkvt_pkg::WAY_W-1:0]         ins_way;

  // Control registers; the request, way, free way and result registers are loaded without reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= bhkvt_pkg::S_CLEAR;
      clr_addr <= '0;
      free_vld <= 1'b0;
    end else begin
      state    <= state_next;
      clr_addr <= clr_addr_next;
      free_vld <= free_vld_next;
    end
    op       <= op_next;
    key      <= key_next;
    value    <= value_next;
    way      <= way_next;
    free_way <= free_way_next;
    rsp      <= rsp_next;
  end

  // Request decode and the compare of the way that the key memory just returned.
  assign accept     = start && !busy;
  assign key_bad    = (request.key == bhkvt_pkg::KEY_EMPTY) ||
                      (request.key == bhkvt_pkg::KEY_DELETED);
  assign req_bucket = request.key[bhkvt_pkg::BUCKET_W-1:0];
  assign bucket     = key[bhkvt_pkg::BUCKET_W-1:0];
  assign cur_addr   = {bucket, way};
  assign slot_empty = key_rdata == bhkvt_pkg::KEY_EMPTY;
  assign slot_del   = key_rdata == bhkvt_pkg::KEY_DELETED;
  assign slot_hit   = key_rdata == key;
  assign last_way   = way == bhkvt_pkg::WAY_W'(bhkvt_pkg::WAYS - 1);
  assign free_here  = slot_empty || slot_del;
  assign ins_way    = free_vld ? free_way : way;

  assign busy   = (state == bhkvt_pkg::S_CLEAR) || (state == bhkvt_pkg::S_SCAN);
  assign done   = state == bhkvt_pkg::S_DONE;
  assign result = rsp;

  // Next state, memory control and result.
  always_comb begin
    state_next        = state;
    clr_addr_next     = clr_addr;
    op_next           = op;
    key_next          = key;
    value_next        = value;
    way_next          = way;
    free_vld_next     = free_vld;
    free_way_next     = free_way;
    rsp_next          = rsp;
    mem_ctl.key_we    = 1'b0;
    mem_ctl.val_we    = 1'b0;
    mem_ctl.wr_addr   = cur_addr;
    mem_ctl.rd_addr   = cur_addr;
    key_wdata         = key;

    unique case (state)
      // Sweep the key memory to empty after reset, one slot per cycle.
      bhkvt_pkg::S_CLEAR: begin
        mem_ctl.key_we  = 1'b1;
        mem_ctl.wr_addr = clr_addr;
        key_wdata       = bhkvt_pkg::KEY_EMPTY;
        clr_addr_next   = clr_addr + 1'b1;
        if (clr_addr == bhkvt_pkg::SLOT_W'(bhkvt_pkg::SLOT_COUNT - 1)) begin
          state_next = bhkvt_pkg::S_IDLE;
        end
      end

      // Waiting, or showing a result; both take a new request and read way 0.
      bhkvt_pkg::S_IDLE, bhkvt_pkg::S_DONE: begin
        state_next      = bhkvt_pkg::S_IDLE;
        mem_ctl.rd_addr = {req_bucket, bhkvt_pkg::WAY_W'(0)};
        if (accept) begin
          op_next       = request.operation;
          key_next      = request.key;
          value_next    = request.value;
          way_next      = '0;
          free_vld_next = 1'b0;
          if (key_bad) begin
            rsp_next   = '{status: bhkvt_pkg::STAT_INVALID, value_res: '0, slot: '0};
            state_next = bhkvt_pkg::S_DONE;
          end else begin
            state_next = bhkvt_pkg::S_SCAN;
          end
        end
      end

      // One way per cycle: compare it and read the next one.
      bhkvt_pkg::S_SCAN: begin
        way_next        = way + 1'b1;
        mem_ctl.rd_addr = {bucket, way_next};
        if (op == bhkvt_pkg::OP_UPDATE) begin
          if (free_here && !free_vld) begin
            free_vld_next = 1'b1;
            free_way_next = way;
          end
          priority if (slot_hit) begin
            // Existing key: overwrite its word.
            mem_ctl.val_we = 1'b1;
            rsp_next   = '{status: bhkvt_pkg::STAT_OK, value_res: value,
                           slot: bhkvt_pkg::SLOT_OUT_W'(cur_addr)};
            state_next = bhkvt_pkg::S_DONE;
          end else if (slot_empty || last_way) begin
            // No match in the bucket: fill the first free slot, if any.
            if (free_vld || free_here) begin
              mem_ctl.key_we  = 1'b1;
              mem_ctl.val_we  = 1'b1;
              mem_ctl.wr_addr = {bucket, ins_way};
              rsp_next = '{status: bhkvt_pkg::STAT_OK, value_res: value,
                           slot: bhkvt_pkg::SLOT_OUT_W'({bucket, ins_way})};
            end else begin
              rsp_next = '{status: bhkvt_pkg::STAT_FULL, value_res: '0, slot: '0};
            end
            state_next = bhkvt_pkg::S_DONE;
          end else begin
            state_next = bhkvt_pkg::S_SCAN;
          end
        end else begin
          priority if (slot_hit) begin
            // Found; a delete leaves a tombstone behind.
            if (op == bhkvt_pkg::OP_DELETE) begin
              mem_ctl.key_we = 1'b1;
              key_wdata      = bhkvt_pkg::KEY_DELETED;
            end
            rsp_next   = '{status: bhkvt_pkg::STAT_OK, value_res: val_rdata,
                           slot: bhkvt_pkg::SLOT_OUT_W'(cur_addr)};
            state_next = bhkvt_pkg::S_DONE;
          end else if (slot_empty || last_way) begin
            rsp_next   = '{status: bhkvt_pkg::STAT_NOT_FOUND, value_res: '0, slot: '0};
            state_next = bhkvt_pkg::S_DONE;
          end else begin
            state_next = bhkvt_pkg::S_SCAN;
          end
        end
      end

      default: begin
        state_next = bhkvt_pkg::S_CLEAR;
      end
    endcase
  end

endmodule

`default_nettype wire
